/* design/dke_pkg.sv */
// ----------------------------------------------------------------------------
// dke_pkg
// Shared types, codes and pipeline constants of the distance kernel evaluator.
// ----------------------------------------------------------------------------
package dke_pkg;

  // Kernel selection
  typedef enum logic [1:0] {
    MODE_CONST  = 2'd0,
    MODE_GAUSS  = 2'd1,
    MODE_LINEAR = 2'd2,
    MODE_EXP    = 2'd3
  } mode_e;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_MODE  = 3'd0,
    REG_OFFSET_C     = 3'd1,
    REG_GAIN_A       = 3'd2,
    REG_CENTER_MEAN  = 3'd3,
    REG_DECAY_SCALE  = 3'd4,
    REG_MAX_DISTANCE = 3'd5,
    REG_CLAMP_MIN    = 3'd6,
    REG_CLAMP_MAX    = 3'd7
  } reg_e;

  // Periodic wrap: restoring reduction, three steps per stage
  localparam int WRAP_STEPS  = 33;
  localparam int WRAP_PER    = 3;
  localparam int WRAP_STAGES = (WRAP_STEPS + WRAP_PER - 1) / WRAP_PER;
  localparam int WRAP_LAT    = WRAP_STAGES + 2;

  // Square root: 32 result bits, two per stage
  localparam int SQRT_ITERS  = 32;
  localparam int SQRT_PER    = 2;
  localparam int SQRT_STAGES = SQRT_ITERS / SQRT_PER;

  // exp(-x): ln2 reduction, Taylor series, final shift
  localparam logic [31:0] LN2_Q32     = 32'd2977044472;
  localparam int          K_BITS      = 7;
  localparam int          TERMS       = 13;
  localparam int          RECIP_SHIFT = 36;
  localparam int          EXP_LAT     = 2 + 3 * TERMS + 1;

  // floor(2^36 / i), i = 1..13
  localparam logic [36:0] RECIP [1:TERMS] = '{
    37'd68719476736, 37'd34359738368, 37'd22906492245, 37'd17179869184,
    37'd13743895347, 37'd11453246122, 37'd9817068105,  37'd8589934592,
    37'd7635497415,  37'd6871947673,  37'd6247225157,  37'd5726623061,
    37'd5286113595
  };

endpackage

/* design/dke_if.sv */
// ----------------------------------------------------------------------------
// dke_if
// Valid/ready channels of the distance kernel evaluator.
// ----------------------------------------------------------------------------

// Position pair word
interface dke_pos_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] driver_x;
  logic signed [31:0] driver_y;
  logic signed [31:0] pool_x;
  logic signed [31:0] pool_y;

  modport source (output valid, driver_x, driver_y, pool_x, pool_y, input ready);
  modport sink   (input valid, driver_x, driver_y, pool_x, pool_y, output ready);
endinterface

// Kernel result word
interface dke_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] kernel_value;
  logic               beyond_cutoff;

  modport source (output valid, kernel_value, beyond_cutoff, input ready);
  modport sink   (input valid, kernel_value, beyond_cutoff, output ready);
endinterface

// Configuration write word
interface dke_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dke_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/dke_wrap.sv */
// ----------------------------------------------------------------------------
// dke_wrap
// Per-axis periodic wrap into (-E/2, E/2], absolute value, saturation at 2^31.
// ----------------------------------------------------------------------------
module dke_wrap #(
  parameter int unsigned EXT = 0
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [34:0] d_i,
  output logic [31:0]        a_o
);

  localparam int NS  = dke_pkg::WRAP_STAGES;
  localparam int PER = dke_pkg::WRAP_PER;
  localparam logic [65:0] EXT_W66 = 66'(EXT);
  localparam logic [34:0] EXT_W35 = 35'(EXT);

  logic [33:0] acc_q [NS+1];
  logic        neg_q [NS+1];
  logic [31:0] a_q;
  logic [31:0] a_d;

  // Stage 0: magnitude and sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0] <= d_i[34];
      acc_q[0] <= d_i[34] ? 34'(-d_i) : 34'(d_i);
    end
  end

  // Restoring reduction by EXT, high multiples first
  for (genvar g = 0; g < NS; g++) begin : g_red
    logic [33:0] acc_d;
    always_comb begin
      int k;
      acc_d = acc_q[g];
      for (int j = 0; j < PER; j++) begin
        k = dke_pkg::WRAP_STEPS - 1 - g * PER - j;
        if (k >= 0) begin
          if ({32'b0, acc_d} >= (EXT_W66 << k)) begin
            acc_d = acc_d - 34'(EXT_W66 << k);
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[g+1] <= acc_d;
        neg_q[g+1] <= neg_q[g];
      end
    end
  end

  // Fold into the centered interval, take magnitude, saturate
  always_comb begin
    logic [34:0] r;
    logic [34:0] rp;
    logic [34:0] av;
    r  = {1'b0, acc_q[NS]};
    rp = r;
    av = r;
    if (EXT != 0) begin
      rp = (neg_q[NS] && (r != '0)) ? (EXT_W35 - r) : r;
      av = ((rp << 1) > EXT_W35) ? (EXT_W35 - rp) : rp;
    end
    a_d = (av > 35'h0_8000_0000) ? 32'h8000_0000 : av[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
    end
  end

  assign a_o = a_q;

endmodule

/* design/dke_sqrt.sv */
// ----------------------------------------------------------------------------
// dke_sqrt
// Pipelined integer square root of a 64-bit value, two result bits a stage.
// ----------------------------------------------------------------------------
module dke_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] s_i,
  output logic [31:0] l_o
);

  localparam int NS  = dke_pkg::SQRT_STAGES;
  localparam int PER = dke_pkg::SQRT_PER;

  logic [63:0] v_q [NS];
  logic [63:0] r_q [NS];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic [63:0] v_d;
    logic [63:0] r_d;
    always_comb begin
      logic [63:0] bitv;
      if (g == 0) begin
        v_d = s_i;
        r_d = '0;
      end else begin
        v_d = v_q[g-1];
        r_d = r_q[g-1];
      end
      // one trial subtraction per result bit
      for (int j = 0; j < PER; j++) begin
        bitv = 64'(1) << (62 - 2 * (g * PER + j));
        if (v_d >= r_d + bitv) begin
          v_d = v_d - (r_d + bitv);
          r_d = (r_d >> 1) + bitv;
        end else begin
          r_d = r_d >> 1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[g] <= v_d;
        r_q[g] <= r_d;
      end
    end
  end

  assign l_o = r_q[NS-1][31:0];

endmodule

/* design/dke_exp.sv */
// ----------------------------------------------------------------------------
// dke_exp
// Pipelined exp(-x): ln2 range reduction, 13-term Taylor series in Q32,
// final shift back to FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module dke_exp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [FRAC_BITS+6:0] x_i,
  output logic [32:0]          e_o
);

  localparam int TERMS = dke_pkg::TERMS;
  localparam int KB    = dke_pkg::K_BITS;
  localparam logic [38:0] LN2_W = 39'(dke_pkg::LN2_Q32);

  typedef struct packed {
    logic [32:0]        term;
    logic signed [34:0] sum;
    logic [31:0]        r;
    logic [KB-1:0]      k;
  } est_t;

  logic [38:0] rem1_q;
  logic [3:0]  kh_q;
  est_t        c_q  [TERMS+1];
  est_t        a_q  [1:TERMS];
  est_t        b_q  [1:TERMS];
  logic [69:0] pm_q [1:TERMS];
  logic [32:0] e_q;

  // Reduction, upper quotient bits
  always_ff @(posedge clk_i) begin
    logic [38:0] rem;
    logic [38:0] sh;
    logic [3:0]  kh;
    rem = 39'(x_i) << (32 - FRAC_BITS);
    kh  = '0;
    for (int j = 0; j < 4; j++) begin
      sh = LN2_W << (6 - j);
      if (rem >= sh) begin
        rem       = rem - sh;
        kh[3 - j] = 1'b1;
      end
    end
    if (en_i) begin
      rem1_q <= rem;
      kh_q   <= kh;
    end
  end

  // Reduction, lower quotient bits; series starts at 1.0
  always_ff @(posedge clk_i) begin
    logic [38:0] rem;
    logic [38:0] sh;
    logic [2:0]  kl;
    rem = rem1_q;
    kl  = '0;
    for (int j = 0; j < 3; j++) begin
      sh = LN2_W << (2 - j);
      if (rem >= sh) begin
        rem       = rem - sh;
        kl[2 - j] = 1'b1;
      end
    end
    if (en_i) begin
      c_q[0].term <= 33'h1_0000_0000;
      c_q[0].sum  <= 35'sh1_0000_0000;
      c_q[0].r    <= rem[31:0];
      c_q[0].k    <= {kh_q, kl};
    end
  end

  // Taylor terms: multiply by r, multiply by reciprocal of i, correct, then add or subtract by sign
  for (genvar t = 1; t <= TERMS; t++) begin : g_term
    logic [64:0] prod_a;
    est_t        c_d;

    assign prod_a = 65'(c_q[t-1].term) * 65'(c_q[t-1].r);

    always_comb begin
      logic [33:0] q0;
      logic [37:0] rm;
      logic [33:0] q;
      q0 = pm_q[t][69:dke_pkg::RECIP_SHIFT];
      rm = 38'(b_q[t].term) - 38'(q0) * 38'(t);
      q  = (rm >= 38'(t)) ? (q0 + 34'd1) : q0;
      c_d      = b_q[t];
      c_d.term = q[32:0];
      if ((t % 2) == 1) begin
        c_d.sum = b_q[t].sum - 35'(q);
      end else begin
        c_d.sum = b_q[t].sum + 35'(q);
      end
    end

    always_ff @(posedge clk_i) begin
      est_t a_d;
      a_d      = c_q[t-1];
      a_d.term = prod_a[64:32];
      if (en_i) begin
        a_q[t]  <= a_d;
        b_q[t]  <= a_q[t];
        pm_q[t] <= 70'(a_q[t].term) * 70'(dke_pkg::RECIP[t]);
        c_q[t]  <= c_d;
      end
    end
  end

  // Scale by 2^-k and drop to FRAC_BITS fraction bits
  always_ff @(posedge clk_i) begin
    logic [7:0]  shift;
    logic [34:0] sv;
    shift = 8'(c_q[TERMS].k) + 8'(32 - FRAC_BITS);
    sv    = 35'(c_q[TERMS].sum);
    if (en_i) begin
      e_q <= (shift >= 8'd64) ? '0 : 33'(sv >> shift);
    end
  end

  assign e_o = e_q;

endmodule

/* design/distance_kernel_evaluator_top.sv */
// Throughput: one word per cycle; the whole pipeline advances whenever the
// output register is empty or being taken, so a stalled output holds every stage.
// Depth is set by the wrap reduction (13), square root (16) and exp(-x) (42).
// Reset clears all valid bits and loads the configuration register defaults.
// ----------------------------------------------------------------------------
// distance_kernel_evaluator_top
// Distance-dependent connection kernel: displacement, wrap, length, cutoff,
// constant/gaussian/linear/exponential kernel and bounding.
// ----------------------------------------------------------------------------
module distance_kernel_evaluator_top #(
  parameter int          ANCHOR_X      = 0,
  parameter int          ANCHOR_Y      = 0,
  parameter int unsigned WRAP_EXTENT_X = 0,
  parameter int unsigned WRAP_EXTENT_Y = 0,
  parameter int          VALUE_FLOOR   = -2147483648,
  parameter int          FRAC_BITS     = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dke_pos_if.sink  pos_i,
  dke_res_if.source res_o,
  dke_cfg_if.sink  cfg_i
);

  localparam int XW    = FRAC_BITS + 7;
  localparam int QW    = 64 - FRAC_BITS;
  localparam int LD_N  = 3 + dke_pkg::EXP_LAT;
  localparam int CUT_N = dke_pkg::SQRT_STAGES + 3 + dke_pkg::EXP_LAT + 3;
  localparam int LAT   = dke_pkg::WRAP_LAT + 2 + dke_pkg::SQRT_STAGES + 3
                         + dke_pkg::EXP_LAT + 3;
  localparam logic [XW-1:0]     X_LIMIT = {1'b1, {(XW-1){1'b0}}};
  localparam logic signed [66:0] FLOOR_W = 67'(VALUE_FLOOR);

  // Configuration registers
  dke_pkg::mode_e     mode_q;
  logic signed [31:0] offset_q;
  logic signed [31:0] gain_q;
  logic signed [31:0] mean_q;
  logic [30:0]        decay_q;
  logic [30:0]        maxd_q;
  logic signed [31:0] cmin_q;
  logic signed [31:0] cmax_q;
  logic [61:0]        dsq_q;

  // Pipeline control
  logic           en;
  logic [LAT-1:0] vld_q;
  logic [CUT_N-1:0] cut_q;

  // Datapath
  logic signed [34:0] dx;
  logic signed [34:0] dy;
  logic [31:0]        ax;
  logic [31:0]        ay;
  logic [63:0]        sqx_q;
  logic [63:0]        sqy_q;
  logic [63:0]        ssum_q;
  logic [31:0]        len;
  logic [QW-1:0]      k1q_q;
  logic [62:0]        prod2_q;
  logic               big_q;
  logic [XW-1:0]      x3_q;
  logic [31:0]        ld_q [LD_N];
  logic [32:0]        e;
  logic signed [65:0] prod_q;
  logic signed [66:0] v_q;
  logic signed [31:0] kv_q;
  logic               bc_q;

  // Configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= dke_pkg::MODE_CONST;
      offset_q <= '0;
      gain_q   <= 32'sd65536;
      mean_q   <= '0;
      decay_q  <= 31'd65536;
      maxd_q   <= 31'h7FFF_FFFF;
      cmin_q   <= 32'sh8000_0000;
      cmax_q   <= 32'sh7FFF_FFFF;
      dsq_q    <= 62'h3FFF_FFFF_0000_0001;
    end else begin
      dsq_q <= 62'(maxd_q) * 62'(maxd_q);
      if (cfg_i.valid) begin
        unique case (dke_pkg::reg_e'(cfg_i.index))
          dke_pkg::REG_KERNEL_MODE:  mode_q   <= dke_pkg::mode_e'(cfg_i.data[1:0]);
          dke_pkg::REG_OFFSET_C:     offset_q <= cfg_i.data;
          dke_pkg::REG_GAIN_A:       gain_q   <= cfg_i.data;
          dke_pkg::REG_CENTER_MEAN:  mean_q   <= cfg_i.data;
          dke_pkg::REG_DECAY_SCALE:  decay_q  <= cfg_i.data[30:0];
          dke_pkg::REG_MAX_DISTANCE: maxd_q   <= cfg_i.data[30:0];
          dke_pkg::REG_CLAMP_MIN:    cmin_q   <= cfg_i.data;
          dke_pkg::REG_CLAMP_MAX:    cmax_q   <= cfg_i.data;
        endcase
      end
    end
  end

  // Global advance: output register free or being taken
  assign en          = !vld_q[LAT-1] || res_o.ready;
  assign pos_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], pos_i.valid};
    end
  end

  // Displacement plus anchor
  assign dx = 35'(pos_i.driver_x) - 35'(pos_i.pool_x) + 35'(ANCHOR_X);
  assign dy = 35'(pos_i.driver_y) - 35'(pos_i.pool_y) + 35'(ANCHOR_Y);

  dke_wrap #(.EXT(WRAP_EXTENT_X)) u_wrap_x (
    .clk_i (clk_i), .en_i (en), .d_i (dx), .a_o (ax)
  );

  dke_wrap #(.EXT(WRAP_EXTENT_Y)) u_wrap_y (
    .clk_i (clk_i), .en_i (en), .d_i (dy), .a_o (ay)
  );

  // Squares, then sum and cutoff test
  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q  <= 64'(ax) * 64'(ax);
      sqy_q  <= 64'(ay) * 64'(ay);
      ssum_q <= sqx_q + sqy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_q <= '0;
    end else if (en) begin
      cut_q <= {cut_q[CUT_N-2:0], ((sqx_q + sqy_q) > {2'b00, dsq_q})};
    end
  end

  dke_sqrt u_sqrt (
    .clk_i (clk_i), .en_i (en), .s_i (ssum_q), .l_o (len)
  );

  // K1: gaussian offset square
  always_ff @(posedge clk_i) begin
    logic signed [33:0] tt;
    logic [32:0]        at;
    logic [65:0]        sq;
    tt = $signed({2'b00, len}) - 34'(mean_q);
    at = tt[33] ? 33'(-tt) : 33'(tt);
    sq = 66'(at) * 66'(at);
    if (en) begin
      k1q_q <= sq[63:FRAC_BITS];
    end
  end

  // K2: times decay scale, with overflow flag for the gaussian
  always_ff @(posedge clk_i) begin
    logic [31:0] op;
    op = (mode_q == dke_pkg::MODE_GAUSS) ? k1q_q[31:0] : ld_q[0];
    if (en) begin
      prod2_q <= 63'(op) * 63'(decay_q);
      big_q   <= (mode_q == dke_pkg::MODE_GAUSS) && (|k1q_q[QW-1:32])
                 && (decay_q != '0);
    end
  end

  // K3: exponent argument, limited to 64.0
  always_ff @(posedge clk_i) begin
    logic [62:0] xs;
    xs = prod2_q >> FRAC_BITS;
    if (en) begin
      x3_q <= (big_q || (xs > 63'(X_LIMIT))) ? X_LIMIT : XW'(xs);
    end
  end

  // Length rides along until the final product
  always_ff @(posedge clk_i) begin
    if (en) begin
      ld_q[0] <= len;
      for (int i = 1; i < LD_N; i++) begin
        ld_q[i] <= ld_q[i-1];
      end
    end
  end

  dke_exp #(.FRAC_BITS(FRAC_BITS)) u_exp (
    .clk_i (clk_i), .en_i (en), .x_i (x3_q), .e_o (e)
  );

  // Product with gain, then shift and offset; constant mode takes the offset alone
  always_ff @(posedge clk_i) begin
    logic [32:0]        op;
    logic signed [65:0] vs;
    op = (mode_q == dke_pkg::MODE_LINEAR) ? {1'b0, ld_q[LD_N-1]} : e;
    vs = prod_q >>> FRAC_BITS;
    if (en) begin
      prod_q <= 66'(gain_q) * $signed({1'b0, 65'(op)});
      v_q    <= (mode_q == dke_pkg::MODE_CONST) ? 67'(offset_q)
                                                : 67'(vs) + 67'(offset_q);
    end
  end

  // Floor, clamp and cutoff into the output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      bc_q <= cut_q[CUT_N-1];
      priority if (cut_q[CUT_N-1]) begin
        kv_q <= '0;
      end else if (v_q < FLOOR_W) begin
        kv_q <= '0;
      end else if (v_q < 67'(cmin_q)) begin
        kv_q <= cmin_q;
      end else if (v_q > 67'(cmax_q)) begin
        kv_q <= cmax_q;
      end else begin
        kv_q <= v_q[31:0];
      end
    end
  end

  assign res_o.valid         = vld_q[LAT-1];
  assign res_o.kernel_value  = kv_q;
  assign res_o.beyond_cutoff = bc_q;

endmodule

/* design/dke_checker.sv */
// ----------------------------------------------------------------------------
// dke_checker
// Port-level checks of the distance kernel evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module dke_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [31:0] kernel_value_i,
  input logic               beyond_cutoff_i
);

  // A result word waits until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // Cutoff results carry a zero value
  a_cut_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && beyond_cutoff_i |-> kernel_value_i == 32'sd0)
    else $error("cutoff result with nonzero value");

  // Input is taken exactly when the output register can move
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> (in_ready_i == (!out_valid_i || out_ready_i)))
    else $error("input ready does not follow output stall");

  // Nothing comes out right after reset
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result word right after reset");

endmodule

bind distance_kernel_evaluator_top dke_checker u_dke_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (pos_i.valid),
  .in_ready_i      (pos_i.ready),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .kernel_value_i  (res_o.kernel_value),
  .beyond_cutoff_i (res_o.beyond_cutoff)
);

/* dv/distance_kernel_evaluator_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_kernel_evaluator_top_tb
// Self-checking bench for the distance kernel evaluator. Position words are
// streamed through the block under several register settings. Each result is
// compared with a bit-exact predictor of the kernel pipeline. Both channel
// sides idle at random, and the result side also holds off for one long stretch.
// ----------------------------------------------------------------------------
module distance_kernel_evaluator_top_tb;

  localparam int     FB       = 16;
  localparam int     FLOOR_V  = -2147483648;
  localparam int     LAT      = 79;
  localparam longint LIMIT    = 400000;
  localparam longint XMAX     = 64 << FB;

  typedef struct packed {
    logic signed [31:0] dx_drv;
    logic signed [31:0] dy_drv;
    logic signed [31:0] px_pool;
    logic signed [31:0] py_pool;
  } pos_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               cutoff;
  } res_t;

  logic clk_i;
  logic rst_ni;

  dke_pos_if pos_if ();
  dke_res_if res_if ();
  dke_cfg_if cfg_if ();

  distance_kernel_evaluator_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pos_i  (pos_if.sink),
    .res_o  (res_if.source),
    .cfg_i  (cfg_if.sink)
  );

  // Shadow copy of the kernel registers
  dke_pkg::mode_e     sh_mode;
  logic signed [31:0] sh_offset;
  logic signed [31:0] sh_gain;
  logic signed [31:0] sh_center;
  logic [30:0]        sh_decay;
  logic [30:0]        sh_maxd;
  logic signed [31:0] sh_cmin;
  logic signed [31:0] sh_cmax;

  pos_t   pending_pos[$];
  res_t   kernel_expect[$];
  int     errors;
  int     checked;
  int     cutoff_seen;
  int     sent_words;
  longint cycles;
  int     src_idle_pct;
  int     snk_idle_pct;
  int     hold_cycles;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint floor_shift(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint wrapped_abs(longint d);
    longint a;
    a = (d < 0) ? -d : d;
    if (a > (64'sd1 << 31)) a = 64'sd1 << 31;
    return a;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // exp(-x) in the block's fixed point, ln2 reduction plus Taylor series
  function automatic longint unsigned decay_exp(longint unsigned x);
    longint unsigned x32, k, r, term, sh;
    longint          acc;
    if (x > XMAX) x = XMAX;
    x32  = x << (32 - FB);
    k    = x32 / 64'd2977044472;
    r    = x32 - k * 64'd2977044472;
    term = 64'd1 << 32;
    acc  = term;
    for (int i = 1; i <= 13; i++) begin
      term = ((term * r) >> 32) / i;
      if (i % 2) acc -= term;
      else       acc += term;
    end
    sh = k + 32 - FB;
    if (sh >= 64) return 0;
    return longint'(acc) >> sh;
  endfunction

  function automatic res_t kernel_of(pos_t p);
    res_t            r;
    longint          dx, dy, v, t;
    longint unsigned ax, ay, s2, len, x, q, at;
    dx = longint'(p.dx_drv) - longint'(p.px_pool);
    dy = longint'(p.dy_drv) - longint'(p.py_pool);
    ax = wrapped_abs(dx);
    ay = wrapped_abs(dy);
    s2 = ax * ax + ay * ay;
    r.cutoff = 1'b0;
    if (s2 > longint'(sh_maxd) * longint'(sh_maxd)) begin
      r.value  = '0;
      r.cutoff = 1'b1;
      return r;
    end
    len = int_sqrt(s2);
    x   = 0;
    case (sh_mode)
      dke_pkg::MODE_CONST:  v = sh_offset;
      dke_pkg::MODE_LINEAR: v = floor_shift(longint'(sh_gain) * longint'(len), FB)
                                + sh_offset;
      default: begin
        if (sh_mode == dke_pkg::MODE_GAUSS) begin
          t  = longint'(len) - longint'(sh_center);
          at = (t < 0) ? -t : t;
          q  = (at * at) >> FB;
          if (sh_decay == 0)       x = 0;
          else if (q >= 64'd1 << 32) x = XMAX;
          else                     x = (q * sh_decay) >> FB;
        end else begin
          x = (len * sh_decay) >> FB;
        end
        if (x > XMAX) x = XMAX;
        v = floor_shift(longint'(sh_gain) * longint'(decay_exp(x)), FB) + sh_offset;
      end
    endcase
    if (v < FLOOR_V)      v = 0;
    else if (v < sh_cmin) v = sh_cmin;
    else if (v > sh_cmax) v = sh_cmax;
    r.value = v[31:0];
    return r;
  endfunction

  // Driver: offers pending position words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_if.valid <= 1'b0;
      {pos_if.driver_x, pos_if.driver_y, pos_if.pool_x, pos_if.pool_y} <= '0;
    end else begin
      if (pos_if.valid && pos_if.ready) begin
        kernel_expect = {kernel_expect, kernel_of({pos_if.driver_x, pos_if.driver_y,
                                                   pos_if.pool_x, pos_if.pool_y})};
        sent_words++;
      end
      if ((!pos_if.valid || pos_if.ready) && pending_pos.size() > 0 &&
          $urandom_range(99) >= src_idle_pct) begin
        pos_t w;
        w = pending_pos.pop_front();
        pos_if.valid    <= 1'b1;
        pos_if.driver_x <= w.dx_drv;
        pos_if.driver_y <= w.dy_drv;
        pos_if.pool_x   <= w.px_pool;
        pos_if.pool_y   <= w.py_pool;
      end else if (pos_if.ready) begin
        pos_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: result side ready and checking
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (kernel_expect.size() == 0) begin
          $error("result word with nothing expected: value %0d", res_if.kernel_value);
          errors++;
        end else begin
          res_t e;
          e = kernel_expect.pop_front();
          checked++;
          if (e.cutoff) cutoff_seen++;
          if (res_if.kernel_value !== e.value) begin
            $error("kernel_value expected %0d actual %0d", e.value, res_if.kernel_value);
            errors++;
          end
          if (res_if.beyond_cutoff !== e.cutoff) begin
            $error("beyond_cutoff expected %0b actual %0b", e.cutoff,
                   res_if.beyond_cutoff);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("distance_kernel_evaluator_top verification failed");
      $finish;
    end
  end

  task automatic write_reg(dke_pkg::reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      dke_pkg::REG_KERNEL_MODE:  sh_mode   = dke_pkg::mode_e'(val[1:0]);
      dke_pkg::REG_OFFSET_C:     sh_offset = val;
      dke_pkg::REG_GAIN_A:       sh_gain   = val;
      dke_pkg::REG_CENTER_MEAN:  sh_center = val;
      dke_pkg::REG_DECAY_SCALE:  sh_decay  = val[30:0];
      dke_pkg::REG_MAX_DISTANCE: sh_maxd   = val[30:0];
      dke_pkg::REG_CLAMP_MIN:    sh_cmin   = val;
      dke_pkg::REG_CLAMP_MAX:    sh_cmax   = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_pos.size() > 0 || pos_if.valid || kernel_expect.size() > 0)
      @(posedge clk_i);
    repeat (LAT + 5) @(posedge clk_i);
  endtask

  task automatic push_pos(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                          logic [31:0] d);
    pos_t w;
    w = {a, b, c, d};
    pending_pos = {pending_pos, w};
  endtask

  // Mostly short displacements so kernels see interesting lengths
  function automatic logic [31:0] rand_coord(int span_sel);
    case (span_sel)
      0:       return $urandom;
      1:       return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  task automatic random_batch(int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(3);
      push_pos(rand_coord(sel), rand_coord(sel), rand_coord(sel), rand_coord(sel));
    end
  endtask

  task automatic random_config();
    write_reg(dke_pkg::REG_KERNEL_MODE, $urandom_range(3));
    write_reg(dke_pkg::REG_OFFSET_C, ($urandom_range(3) == 0) ? $urandom
                            : $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
    write_reg(dke_pkg::REG_GAIN_A, ($urandom_range(3) == 0) ? $urandom
                          : $urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
    write_reg(dke_pkg::REG_CENTER_MEAN,
              $urandom_range(0, 32'h0010_0000) - 32'h0004_0000);
    write_reg(dke_pkg::REG_DECAY_SCALE, ($urandom_range(4) == 0) ? 32'd0
                               : $urandom_range(0, 32'h0000_8000));
    write_reg(dke_pkg::REG_MAX_DISTANCE, ($urandom_range(2) == 0) ? 32'h7FFF_FFFF
                                : $urandom_range(0, 32'h0030_0000));
    write_reg(dke_pkg::REG_CLAMP_MIN, $urandom_range(0, 32'h0004_0000) - 32'h0003_0000);
    write_reg(dke_pkg::REG_CLAMP_MAX, $urandom_range(0, 32'h0004_0000) - 32'h0001_0000);
  endtask

  // Stimulus
  initial begin
    errors = 0; checked = 0; cutoff_seen = 0; sent_words = 0; cycles = 0;
    src_idle_pct = 22; snk_idle_pct = 52; hold_cycles = 0;
    sh_mode = dke_pkg::MODE_CONST; sh_offset = 0; sh_gain = 32'sd65536; sh_center = 0;
    sh_decay = 31'd65536; sh_maxd = 31'h7FFF_FFFF;
    sh_cmin = 32'h8000_0000; sh_cmax = 32'h7FFF_FFFF;
    cfg_if.valid = 1'b0; cfg_if.index = dke_pkg::REG_KERNEL_MODE; cfg_if.data = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every mode, field extremes, zero decay, inverted clamp, cutoff
    for (int m = 0; m < 4; m++) begin
      write_reg(dke_pkg::REG_KERNEL_MODE, m);
      write_reg(dke_pkg::REG_OFFSET_C, (m == 0) ? 32'h0001_8000 : 32'h0);
      write_reg(dke_pkg::REG_DECAY_SCALE, (m == 3) ? 32'd0 : 32'h0000_4000);
      push_pos(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      push_pos(32'h0, 32'h0, 32'h0, 32'h0);
      push_pos(32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0);
      push_pos(32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);
      drain();
    end
    write_reg(dke_pkg::REG_GAIN_A, 32'h8000_0000);
    write_reg(dke_pkg::REG_CENTER_MEAN, 32'h7FFF_FFFF);
    write_reg(dke_pkg::REG_MAX_DISTANCE, 32'h0005_0000);
    write_reg(dke_pkg::REG_CLAMP_MIN, 32'h0001_0000);
    write_reg(dke_pkg::REG_CLAMP_MAX, 32'hFFFF_0000);
    push_pos(32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0);
    push_pos(32'h0003_0000, 32'h0004_0001, 32'h0, 32'h0);
    drain();
    write_reg(dke_pkg::REG_KERNEL_MODE, dke_pkg::MODE_GAUSS);
    push_pos(32'h0001_0000, 32'h0, 32'h0, 32'h0);
    drain();
    write_reg(dke_pkg::REG_KERNEL_MODE, dke_pkg::MODE_LINEAR);
    write_reg(dke_pkg::REG_GAIN_A, 32'h7FFF_FFFF);
    write_reg(dke_pkg::REG_OFFSET_C, 32'h7FFF_FFFF);
    write_reg(dke_pkg::REG_MAX_DISTANCE, 32'h7FFF_FFFF);
    write_reg(dke_pkg::REG_CLAMP_MIN, 32'h8000_0000);
    write_reg(dke_pkg::REG_CLAMP_MAX, 32'h7FFF_FFFF);
    push_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    push_pos(32'h0, 32'h0, 32'h0, 32'h0);
    drain();

    // Random phases under the three idle profiles
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin src_idle_pct = 52; snk_idle_pct = 22; end
      if (ph == 6) begin src_idle_pct = 0;  snk_idle_pct = 0;  end
      random_config();
      if (ph == 4) hold_cycles = 300;
      random_batch(70);
      drain();
    end

    $display("checked %0d result words (%0d past cutoff) from %0d position words",
             checked, cutoff_seen, sent_words);
    $display("modes, extremes, wrap-free lengths and clamps over nine settings");
    if (errors == 0 && kernel_expect.size() == 0) begin
      $display("distance_kernel_evaluator_top verification clean");
    end else begin
      $display("distance_kernel_evaluator_top verification failed");
    end
    $finish;
  end
endmodule
